FILE: sv/ocu_pkg.sv
package ocu_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QDEPTH = 2;
	localparam int CFG_IW = 8;

	localparam logic signed [33:0] DEG_90 = 34'sd5898240;
	localparam logic signed [33:0] DEG_180 = 34'sd11796480;
	localparam logic signed [33:0] DEG_360 = 34'sd23592960;
	localparam logic signed [33:0] DEG_360_X183 = 34'sd4317511680;
	localparam logic signed [32:0] INV_GAIN = 33'sd652032874;
	localparam logic signed [66:0] HALF_Q30 = 67'sd536870912;

	localparam logic signed [31:0] PITCH_MIN_RST = 32'sd65536;
	localparam logic signed [31:0] PITCH_MAX_RST = 32'sd11730944;
	localparam logic signed [31:0] PITCH_INIT_RST = 32'sd1310720;
	localparam logic signed [31:0] DIST_INIT_RST = 32'sd655360;

	typedef enum logic [1:0] {
		REG_PITCH_MIN = 2'd0,
		REG_PITCH_MAX = 2'd1,
		REG_PITCH_INIT = 2'd2,
		REG_DIST_INIT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_REINIT = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_RED,
		B_FOLD,
		B_CORD,
		B_MUL,
		B_FIN
	} bstate_t;

	typedef struct packed {
		cmd_t cmd;
		logic signed [31:0] pitch;
		logic signed [31:0] distance;
		logic signed [32:0] theta;
		logic signed [31:0] yaw;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
	} job_t;

	typedef struct packed {
		logic pop;
		logic fin;
	} bstat_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -40'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [25:0] atan_deg(input logic [4:0] i);
		logic signed [25:0] a;
		case (i)
			5'd0: a = 26'sd2949120;
			5'd1: a = 26'sd1740967;
			5'd2: a = 26'sd919879;
			5'd3: a = 26'sd466945;
			5'd4: a = 26'sd234379;
			5'd5: a = 26'sd117304;
			5'd6: a = 26'sd58666;
			5'd7: a = 26'sd29335;
			5'd8: a = 26'sd14668;
			5'd9: a = 26'sd7334;
			5'd10: a = 26'sd3667;
			5'd11: a = 26'sd1833;
			5'd12: a = 26'sd917;
			5'd13: a = 26'sd458;
			5'd14: a = 26'sd229;
			5'd15: a = 26'sd115;
			5'd16: a = 26'sd57;
			5'd17: a = 26'sd29;
			5'd18: a = 26'sd14;
			5'd19: a = 26'sd7;
			5'd20: a = 26'sd4;
			5'd21: a = 26'sd2;
			5'd22: a = 26'sd1;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

endpackage

FILE: sv/orbit_camera_update.sv
// An update item runs the back end through angle reduction, fold and CORDIC twice
// (pitch, then theta) and then the multiply steps before m_tvalid; a reinit item
// goes straight to the finish step. The back end takes a new item only once idle and
// its last result has been taken, paced by the single iterative CORDIC and multiplier.
// A two-entry queue lets the input side keep accepting while the back end works, until it is full.
// arst_n clears the handshake state and restores registers and camera state to defaults.
module orbit_camera_update #(
	parameter int CORDIC_STEPS = ocu_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ocu_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// zoom_delta, right_held, left_held, delta_x, delta_y, target_x, target_y,
	// target_z, target_heading, zero fill
	input  logic [231:0] s_tdata,
	// cmd
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// cam_x, cam_y, cam_z, cam_yaw, cam_pitch
	output logic [159:0] m_tdata
);
	import ocu_pkg::*;

	job_t push_job, head_job;
	logic push, pop, full, empty;
	logic [1:0] count;
	bstat_t stat;
	logic signed [31:0] cx, cy, cz, cyaw, cpitch;

	assign cfg_ready = 1'b1;
	assign m_tdata = {cpitch, cyaw, cz, cy, cx};

	ocu_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(s_tvalid), .in_ready(s_tready), .cmd(s_tuser),
		.zoom_delta(s_tdata[31:0]), .right_held(s_tdata[32]), .left_held(s_tdata[33]),
		.delta_x(s_tdata[65:34]), .delta_y(s_tdata[97:66]),
		.target_x(s_tdata[129:98]), .target_y(s_tdata[161:130]),
		.target_z(s_tdata[193:162]), .target_heading(s_tdata[225:194]),
		.q_full(full), .q_push(push), .q_job(push_job)
	);

	ocu_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .pop(pop),
		.head_job(head_job), .full(full), .empty(empty), .count(count)
	);

	ocu_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(empty), .q_job(head_job), .q_pop(pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cam_x(cx), .cam_y(cy), .cam_z(cz), .cam_yaw(cyaw), .cam_pitch(cpitch),
		.stat(stat)
	);

`ifndef SYNTHESIS
	a_pop_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |-> !m_tvalid && !empty)
		else $error("queue pop with pending result or empty queue");
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(stat.fin))
		else $error("result raised outside finish step");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= 2'(QDEPTH) && !(push && full))
		else $error("queue overflow");
`endif

endmodule

FILE: sv/ocu_front.sv
module ocu_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [ocu_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic cmd,
	input  logic signed [31:0] zoom_delta,
	input  logic right_held,
	input  logic left_held,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] target_heading,
	input  logic q_full,
	output logic q_push,
	output ocu_pkg::job_t q_job
);
	import ocu_pkg::*;

	logic signed [31:0] pitch_min_q, pitch_max_q, pitch_init_q, dist_init_q;
	logic signed [31:0] pitch_q, angle_q, dist_q;
	logic signed [31:0] pitch_d, angle_d, dist_d, p_sat;
	logic signed [32:0] theta;

	assign in_ready = !q_full;
	assign q_push = in_valid && in_ready;

	always_comb begin
		if (cmd == CMD_REINIT) begin
			pitch_d = pitch_init_q;
			angle_d = '0;
			dist_d = dist_init_q;
			p_sat = pitch_init_q;
		end else begin
			dist_d = sat32(40'(dist_q) - 40'(zoom_delta));
			p_sat = sat32(40'(pitch_q) - 40'(delta_y));
			if (!right_held)
				pitch_d = pitch_q;
			else if (p_sat > pitch_max_q)
				pitch_d = pitch_max_q;
			else if (p_sat < pitch_min_q)
				pitch_d = pitch_min_q;
			else
				pitch_d = p_sat;
			angle_d = left_held ? sat32(40'(angle_q) - 40'(delta_x)) : angle_q;
		end
		theta = 33'(target_heading) + 33'(angle_d);
		q_job.cmd = cmd_t'(cmd);
		q_job.pitch = pitch_d;
		q_job.distance = dist_d;
		q_job.theta = theta;
		q_job.yaw = sat32(40'(DEG_180) - 40'(theta));
		q_job.tx = target_x;
		q_job.ty = target_y;
		q_job.tz = target_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_min_q <= PITCH_MIN_RST;
			pitch_max_q <= PITCH_MAX_RST;
			pitch_init_q <= PITCH_INIT_RST;
			dist_init_q <= DIST_INIT_RST;
		end else if (cfg_valid && cfg_index < CFG_IW'(4)) begin
			unique case (cfg_reg_t'(cfg_index[1:0]))
				REG_PITCH_MIN: pitch_min_q <= cfg_data;
				REG_PITCH_MAX: pitch_max_q <= cfg_data;
				REG_PITCH_INIT: pitch_init_q <= cfg_data;
				REG_DIST_INIT: dist_init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_INIT_RST;
			angle_q <= '0;
			dist_q <= DIST_INIT_RST;
		end else if (q_push) begin
			pitch_q <= pitch_d;
			angle_q <= angle_d;
			dist_q <= dist_d;
		end
	end

endmodule

FILE: sv/ocu_queue.sv
module ocu_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ocu_pkg::job_t push_job,
	input  logic pop,
	output ocu_pkg::job_t head_job,
	output logic full,
	output logic empty,
	output logic [1:0] count
);
	import ocu_pkg::*;

	job_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'(QDEPTH);
	assign empty = cnt_q == 2'd0;
	assign count = cnt_q;
	assign head_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: sv/ocu_back.sv
module ocu_back #(
	parameter int CORDIC_STEPS = ocu_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  ocu_pkg::job_t q_job,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] cam_x,
	output logic signed [31:0] cam_y,
	output logic signed [31:0] cam_z,
	output logic signed [31:0] cam_yaw,
	output logic signed [31:0] cam_pitch,
	output ocu_pkg::bstat_t stat
);
	import ocu_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);

	bstate_t state_q, state_d;
	job_t job_q;
	logic pass_q;
	logic [33:0] red_q;
	logic [3:0] k_q;
	logic [IW-1:0] i_q;
	logic signed [32:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic negc_q;
	logic signed [32:0] sp_q, cp_q, st_q, ct_q;
	logic signed [66:0] prod_q;
	logic [2:0] m_q;
	logic signed [33:0] hor_q, vert_q;
	logic signed [36:0] ma_q, mb_q;
	logic out_valid_q;

	logic signed [33:0] red_in, fr, fr2;
	logic [33:0] step_c;
	logic fneg;
	logic signed [32:0] dx, dy;
	logic signed [25:0] at;
	logic signed [33:0] opa;
	logic signed [32:0] opb;
	logic signed [66:0] rnd;

	assign q_pop = state_q == B_IDLE && !q_empty && !out_valid_q;
	assign out_valid = out_valid_q;
	assign stat.pop = q_pop;
	assign stat.fin = state_q == B_FIN;

	always_comb begin
		red_in = 34'(job_q.theta);
		step_c = 34'(DEG_360) << k_q;
		fr = (red_q < 34'(DEG_180)) ? $signed(red_q) : $signed(red_q) - DEG_360;
		fneg = 1'b0;
		fr2 = fr;
		if (fr > DEG_90) begin
			fr2 = DEG_180 - fr;
			fneg = 1'b1;
		end else if (fr < -DEG_90) begin
			fr2 = -DEG_180 - fr;
			fneg = 1'b1;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = atan_deg(5'(i_q));
		case (m_q)
			3'd0: begin opa = 34'(job_q.distance); opb = cp_q; end
			3'd1: begin opa = 34'(job_q.distance); opb = sp_q; end
			3'd2: begin opa = hor_q; opb = st_q; end
			default: begin opa = hor_q; opb = ct_q; end
		endcase
		rnd = (prod_q + HALF_Q30) >>> 30;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_pop) state_d = (q_job.cmd == CMD_REINIT) ? B_FIN : B_RED;
			B_RED: if (k_q == 4'd0) state_d = B_FOLD;
			B_FOLD: state_d = B_CORD;
			B_CORD: if (i_q == IW'(CORDIC_STEPS - 1)) state_d = pass_q ? B_MUL : B_RED;
			B_MUL: if (m_q == 3'd4) state_d = B_FIN;
			B_FIN: state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_FIN)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				job_q <= q_job;
				pass_q <= 1'b0;
				k_q <= 4'd8;
				m_q <= 3'd0;
				ma_q <= '0;
				mb_q <= -37'(q_job.distance);
				vert_q <= 34'(q_job.pitch);
				red_q <= (34'(q_job.pitch) < 0) ? 34'(q_job.pitch) + DEG_360_X183
					: 34'(q_job.pitch);
			end
			B_RED: begin
				if (red_q >= step_c)
					red_q <= red_q - step_c;
				k_q <= k_q - 4'd1;
			end
			B_FOLD: begin
				x_q <= INV_GAIN;
				y_q <= '0;
				z_q <= fr2[25:0];
				negc_q <= fneg;
				i_q <= '0;
			end
			B_CORD: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + IW'(1);
				if (i_q == IW'(CORDIC_STEPS - 1)) begin
					if (pass_q) begin
						st_q <= y_q + (z_q >= 0 ? dy : -dy);
						ct_q <= negc_q ? -(x_q - (z_q >= 0 ? dx : -dx))
							: x_q - (z_q >= 0 ? dx : -dx);
					end else begin
						sp_q <= y_q + (z_q >= 0 ? dy : -dy);
						cp_q <= negc_q ? -(x_q - (z_q >= 0 ? dx : -dx))
							: x_q - (z_q >= 0 ? dx : -dx);
					end
					pass_q <= 1'b1;
					k_q <= 4'd8;
					red_q <= (red_in < 0) ? red_in + DEG_360_X183 : red_in;
				end
			end
			B_MUL: begin
				prod_q <= opa * opb;
				m_q <= m_q + 3'd1;
				case (m_q)
					3'd1: hor_q <= rnd[33:0];
					3'd2: vert_q <= rnd[33:0];
					3'd3: ma_q <= rnd[36:0];
					3'd4: mb_q <= rnd[36:0];
					default: ;
				endcase
			end
			B_FIN: begin
				cam_x <= sat32(40'(job_q.tx) - 40'(ma_q));
				cam_y <= sat32(40'(job_q.ty) + 40'(vert_q));
				cam_z <= sat32(40'(job_q.tz) - 40'(mb_q));
				cam_yaw <= job_q.yaw;
				cam_pitch <= job_q.pitch;
			end
			default: ;
		endcase
	end

endmodule
